// ===== design/mstb_pkg.sv =====
// Shared types, constants and state encoding for the move sequence trie book.
package mstb_pkg;

  localparam int NODES     = 16384;
  localparam int MOVE_BITS = 16;

  // Port widths fixed by the interface.
  localparam int MOVE_W  = 16;
  localparam int NUSED_W = 15;

  // A pointer can hold every node index plus the null value NODES.
  localparam int PTR_W  = $clog2(NODES + 1);
  localparam int ADDR_W = $clog2(NODES);
  localparam int MV_W   = MOVE_BITS;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [MV_W-1:0]  mv_t;

  localparam ptr_t NIL_PTR  = PTR_W'(NODES);
  localparam ptr_t ROOT_PTR = '0;

  typedef struct packed {
    mv_t  mv;
    ptr_t child;
    ptr_t sib;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  localparam node_t EMPTY_NODE = '{mv: '0, child: NIL_PTR, sib: NIL_PTR};

  // Flags from the shared node compare unit.
  typedef struct packed {
    logic empty;
    logic match;
    logic sib_nil;
    logic child_nil;
  } cmp_t;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ISTART,
    S_IWALK,
    S_IDECIDE,
    S_IW_SIB,
    S_IW_CHILD,
    S_ERD,
    S_ECHK,
    S_EPAR,
    S_ECLR,
    S_OPEN,
    S_SWALK,
    S_SREPLY,
    S_DONE
  } state_t;

endpackage

// ===== design/move_sequence_trie_book.sv =====
// Top level of the move sequence trie book: sequencer, node store and result register.
//
// Usage: an opening book held as a prefix tree in a node store of NODES entries.
// Input channel (in_valid / in_stall) carries one transaction per item: an insert
// of one move of a record, or a search step that follows the opponent's move and
// answers the stored reply. Result channel (out_valid / out_stall) returns exactly
// one transaction per item with reply, hit flag, allocated node count and a flag
// for an insert dropped because the store is full.
// Timing: every step costs one node store read, issued one cycle and used the next.
// A search walks the sibling chain of the current level; an insert walks it too,
// with one more step at record start, then writes the changed node and any new
// sibling and child node, and a closing record adds a check and clean-up. One item
// is in work at a time; in_stall is high from acceptance until the result is loaded
// into the output register.
// Reset: rst_n is synchronous; after it is released the block writes the empty root
// node before it takes its first transaction.
// Back pressure: a finished result waits in the block while out_stall is high and
// the output register is still occupied; the next item is taken as soon as the
// result has moved into the output register.
module move_sequence_trie_book import mstb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [MOVE_W-1:0]  in_move_code,
  input  logic               in_record_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [MOVE_W-1:0]  out_reply_move,
  output logic               out_hit,
  output logic [NUSED_W-1:0] out_nodes_used,
  output logic               out_store_full
);

  state_t state_r, state_nxt;

  // Persistent trie state.
  ptr_t next_free_r, next_free_nxt;
  ptr_t scur_r, scur_nxt;
  ptr_t icur_r, icur_nxt;
  ptr_t ipar_r, ipar_nxt;
  logic root_empty_r, root_empty_nxt;
  logic rec_open_r, rec_open_nxt;

  // Per-item working registers.
  mv_t   key_r, key_nxt;
  logic  end_r, end_nxt;
  ptr_t  idx_r, idx_nxt;
  node_t node_r, node_nxt;
  logic  sibneed_r, sibneed_nxt;
  mv_t   reply_r, reply_nxt;
  logic  full_r, full_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [MOVE_W-1:0]  out_reply_r, out_reply_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [NUSED_W-1:0] out_used_r, out_used_nxt;
  logic               out_full_r, out_full_nxt;

  // Node store port.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  node_t             ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [NODE_W-1:0] ram_rdata;
  node_t             rd_node;
  cmp_t              cmp;

  // Decision terms for placing a move.
  mv_t        key_in;
  logic       scur_lost;
  logic       newchild;
  logic [1:0] need;
  ptr_t       free_cnt;
  ptr_t       base_ptr;
  logic       is_full;
  logic       can_load;

  assign key_in    = in_move_code[MV_W-1:0];
  assign scur_lost = (scur_r >= NIL_PTR);
  assign rd_node   = node_t'(ram_rdata);
  assign can_load  = !out_valid_r || !out_stall;

  assign newchild = sibneed_r || (node_r.child >= NIL_PTR);
  assign need     = {1'b0, sibneed_r} + {1'b0, root_empty_r} + {1'b0, newchild};
  assign free_cnt = NIL_PTR - next_free_r;
  assign is_full  = (PTR_W'(need) > free_cnt);
  // Address of the new child slot: after the new sibling and the root, if counted.
  assign base_ptr = next_free_r + PTR_W'(sibneed_r) + PTR_W'(root_empty_r);

  mstb_ram #(
    .WIDTH(NODE_W),
    .DEPTH(NODES)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  mstb_node_cmp u_cmp (
    .node (rd_node),
    .key  (key_r),
    .flags(cmp)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_SEARCH) begin
            if (key_in == '0) begin
              state_nxt = (next_free_r == '0 || scur_lost) ? S_DONE : S_OPEN;
            end else begin
              state_nxt = scur_lost ? S_DONE : S_SWALK;
            end
          end else if (!rec_open_r) begin
            state_nxt = S_ISTART;
          end else begin
            state_nxt = (key_in == '0) ? S_ERD : S_IWALK;
          end
        end
      end
      S_ISTART: begin
        state_nxt = (key_r == '0) ? S_ERD : S_IWALK;
      end
      S_IWALK: begin
        if (cmp.empty || cmp.match || cmp.sib_nil) begin
          state_nxt = S_IDECIDE;
        end
      end
      S_IDECIDE: begin
        if (is_full) begin
          state_nxt = end_r ? S_ERD : S_DONE;
        end else if (sibneed_r) begin
          state_nxt = S_IW_SIB;
        end else if (newchild) begin
          state_nxt = S_IW_CHILD;
        end else begin
          state_nxt = end_r ? S_ERD : S_DONE;
        end
      end
      S_IW_SIB: begin
        state_nxt = S_IW_CHILD;
      end
      S_IW_CHILD: begin
        state_nxt = end_r ? S_ERD : S_DONE;
      end
      S_ERD: begin
        state_nxt = S_ECHK;
      end
      S_ECHK: begin
        state_nxt = (cmp.empty && ipar_r < NIL_PTR) ? S_EPAR : S_DONE;
      end
      S_EPAR: begin
        state_nxt = S_ECLR;
      end
      S_ECLR: begin
        state_nxt = S_DONE;
      end
      S_OPEN: begin
        state_nxt = S_DONE;
      end
      S_SWALK: begin
        if (!cmp.match) begin
          if (cmp.sib_nil) begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = cmp.child_nil ? S_DONE : S_SREPLY;
        end
      end
      S_SREPLY: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (can_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // Datapath, node store control and output register loading.
  always_comb begin
    next_free_nxt  = next_free_r;
    scur_nxt       = scur_r;
    icur_nxt       = icur_r;
    ipar_nxt       = ipar_r;
    root_empty_nxt = root_empty_r;
    rec_open_nxt   = rec_open_r;
    key_nxt        = key_r;
    end_nxt        = end_r;
    idx_nxt        = idx_r;
    node_nxt       = node_r;
    sibneed_nxt    = sibneed_r;
    reply_nxt      = reply_r;
    full_nxt       = full_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_reply_nxt  = out_reply_r;
    out_hit_nxt    = out_hit_r;
    out_used_nxt   = out_used_r;
    out_full_nxt   = out_full_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = EMPTY_NODE;
    ram_raddr      = '0;

    unique case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = ROOT_PTR[ADDR_W-1:0];
        ram_wdata = EMPTY_NODE;
      end
      S_IDLE: begin
        if (in_valid) begin
          key_nxt   = key_in;
          end_nxt   = in_record_end;
          reply_nxt = '0;
          full_nxt  = 1'b0;
          if (in_req_type == REQ_SEARCH) begin
            idx_nxt   = scur_r;
            ram_raddr = scur_r[ADDR_W-1:0];
          end else if (!rec_open_r) begin
            ram_raddr = ROOT_PTR[ADDR_W-1:0];
          end else begin
            idx_nxt   = icur_r;
            ram_raddr = icur_r[ADDR_W-1:0];
          end
        end
      end
      S_ISTART: begin
        // Record start: sample whether the root still has to be counted.
        root_empty_nxt = cmp.empty;
        icur_nxt       = ROOT_PTR;
        ipar_nxt       = NIL_PTR;
        rec_open_nxt   = 1'b1;
        idx_nxt        = ROOT_PTR;
        ram_raddr      = ROOT_PTR[ADDR_W-1:0];
      end
      S_IWALK: begin
        if (!cmp.empty && !cmp.match && !cmp.sib_nil) begin
          idx_nxt   = rd_node.sib;
          ram_raddr = rd_node.sib[ADDR_W-1:0];
        end else begin
          node_nxt    = rd_node;
          sibneed_nxt = !cmp.empty && !cmp.match;
        end
      end
      S_IDECIDE: begin
        if (is_full) begin
          full_nxt = 1'b1;
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = idx_r[ADDR_W-1:0];
          root_empty_nxt = 1'b0;
          next_free_nxt  = base_ptr + PTR_W'(newchild);
          if (sibneed_r) begin
            // Link a new sibling at the old bump pointer; its child follows it.
            ram_wdata     = '{mv: node_r.mv, child: node_r.child, sib: next_free_r};
            ipar_nxt      = next_free_r;
            icur_nxt      = base_ptr;
          end else begin
            ram_wdata     = '{mv: key_r, child: newchild ? base_ptr : node_r.child,
                              sib: node_r.sib};
            ipar_nxt      = idx_r;
            icur_nxt      = newchild ? base_ptr : node_r.child;
          end
        end
      end
      S_IW_SIB: begin
        ram_we    = 1'b1;
        ram_waddr = ipar_r[ADDR_W-1:0];
        ram_wdata = '{mv: key_r, child: icur_r, sib: NIL_PTR};
      end
      S_IW_CHILD: begin
        ram_we    = 1'b1;
        ram_waddr = icur_r[ADDR_W-1:0];
        ram_wdata = EMPTY_NODE;
      end
      S_ERD: begin
        ram_raddr = icur_r[ADDR_W-1:0];
      end
      S_ECHK: begin
        if (cmp.empty && ipar_r < NIL_PTR) begin
          ram_raddr = ipar_r[ADDR_W-1:0];
        end else begin
          rec_open_nxt   = 1'b0;
          icur_nxt       = ROOT_PTR;
          ipar_nxt       = NIL_PTR;
          root_empty_nxt = 1'b0;
        end
      end
      S_EPAR: begin
        // Detach the dangling empty child from its parent.
        ram_we    = 1'b1;
        ram_waddr = ipar_r[ADDR_W-1:0];
        ram_wdata = '{mv: rd_node.mv, child: NIL_PTR, sib: rd_node.sib};
      end
      S_ECLR: begin
        ram_we    = 1'b1;
        ram_waddr = icur_r[ADDR_W-1:0];
        ram_wdata = EMPTY_NODE;
        if (next_free_r != '0) begin
          next_free_nxt = next_free_r - PTR_W'(1);
        end
        rec_open_nxt   = 1'b0;
        icur_nxt       = ROOT_PTR;
        ipar_nxt       = NIL_PTR;
        root_empty_nxt = 1'b0;
      end
      S_OPEN: begin
        reply_nxt = rd_node.mv;
        scur_nxt  = rd_node.child;
      end
      S_SWALK: begin
        if (!cmp.match) begin
          if (cmp.sib_nil) begin
            scur_nxt = idx_r;
          end else begin
            idx_nxt   = rd_node.sib;
            ram_raddr = rd_node.sib[ADDR_W-1:0];
          end
        end else if (cmp.child_nil) begin
          scur_nxt = idx_r;
        end else begin
          ram_raddr = rd_node.child[ADDR_W-1:0];
        end
      end
      S_SREPLY: begin
        reply_nxt = rd_node.mv;
        scur_nxt  = rd_node.child;
      end
      S_DONE: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_reply_nxt = MOVE_W'(reply_r);
          out_hit_nxt   = (reply_r != '0);
          out_used_nxt  = NUSED_W'(next_free_r);
          out_full_nxt  = full_r;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      next_free_r  <= '0;
      scur_r       <= ROOT_PTR;
      icur_r       <= ROOT_PTR;
      ipar_r       <= NIL_PTR;
      root_empty_r <= 1'b0;
      rec_open_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_free_r  <= next_free_nxt;
      scur_r       <= scur_nxt;
      icur_r       <= icur_nxt;
      ipar_r       <= ipar_nxt;
      root_empty_r <= root_empty_nxt;
      rec_open_r   <= rec_open_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    end_r       <= end_nxt;
    idx_r       <= idx_nxt;
    node_r      <= node_nxt;
    sibneed_r   <= sibneed_nxt;
    reply_r     <= reply_nxt;
    full_r      <= full_nxt;
    out_reply_r <= out_reply_nxt;
    out_hit_r   <= out_hit_nxt;
    out_used_r  <= out_used_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_reply_move = out_reply_r;
  assign out_hit        = out_hit_r;
  assign out_nodes_used = out_used_r;
  assign out_store_full = out_full_r;

endmodule

// ===== design/mstb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module mstb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/mstb_node_cmp.sv =====
// Shared compare unit: checks one node read from the store against the key.
module mstb_node_cmp import mstb_pkg::*; (
  input  node_t node,
  input  mv_t   key,
  output cmp_t  flags
);

  always_comb begin
    flags.empty     = (node.mv == '0);
    flags.match     = (node.mv == key);
    flags.sib_nil   = (node.sib >= NIL_PTR);
    flags.child_nil = (node.child >= NIL_PTR);
  end

endmodule
